@@ rtl/wfu_pkg.sv @@
package wfu_pkg;

	// length codes carried in the low seven bits of the second header byte
	localparam logic [6:0] LEN_CODE_MASK = 7'h7F;
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	// header byte counts
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES = 4'd4;

	// entries in the queue between parser and output stage
	localparam int QUEUE_DEPTH = 4;

endpackage

@@ rtl/wfu_stream_if.sv @@
interface wfu_byte_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface wfu_frame_if #(parameter int LEN_WIDTH = 31);
	logic valid;
	logic ready;
	logic [7:0] payload_byte;
	logic last_byte;
	logic [LEN_WIDTH-1:0] frame_length;
	logic length_error;

	modport source (output valid, output payload_byte, output last_byte,
		output frame_length, output length_error, input ready);
	modport sink (input valid, input payload_byte, input last_byte,
		input frame_length, input length_error, output ready);
endinterface

@@ rtl/wfu_parser.sv @@
module wfu_parser #(
	parameter int LEN_WIDTH = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	wfu_byte_if.sink              stream,
	output logic                  q_valid,
	input  logic                  q_ready,
	output logic [LEN_WIDTH+17:0] q_data
);
	import wfu_pkg::*;

	typedef enum logic [2:0] {HDR0, HDR1, EXT, KEY, DATA} phase_t;

	phase_t               phase_q;
	logic [3:0]           hcount_q;
	logic                 ext_long_q;
	logic [LEN_WIDTH-1:0] decl_q;
	logic [31:0]          key_q;
	logic [LEN_WIDTH-1:0] done_q;
	logic                 too_long_q;

	logic                 accept;
	logic [6:0]           code;
	logic [3:0]           hcount_next;
	logic                 ext_done;
	logic [LEN_WIDTH-1:0] done_next;
	logic                 last;
	logic [7:0]           key_byte;

	assign code        = stream.in_byte[6:0] & LEN_CODE_MASK;
	assign hcount_next = hcount_q + 4'd1;
	assign ext_done    = hcount_next == (ext_long_q ? EXT64_BYTES : EXT16_BYTES);
	assign done_next   = done_q + 1'b1;
	assign last        = done_next >= decl_q;
	assign key_byte    = key_q[8*done_q[1:0] +: 8];

	// header bytes never wait on the queue
	assign stream.ready = (phase_q != DATA) || q_ready;
	assign q_valid      = stream.valid && (phase_q == DATA);
	assign q_data       = {too_long_q, decl_q, last, key_byte, stream.in_byte};
	assign accept       = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= HDR0;
			hcount_q   <= '0;
			ext_long_q <= 1'b0;
			decl_q     <= '0;
			key_q      <= '0;
			done_q     <= '0;
			too_long_q <= 1'b0;
		end else if (accept) begin
			unique case (phase_q)
				HDR0: begin
					hcount_q <= '0;
					phase_q  <= HDR1;
				end
				HDR1: begin
					decl_q     <= '0;
					too_long_q <= 1'b0;
					key_q      <= '0;
					done_q     <= '0;
					hcount_q   <= '0;
					if (code == LEN_CODE_EXT16) begin
						ext_long_q <= 1'b0;
						phase_q    <= EXT;
					end else if (code == LEN_CODE_EXT64) begin
						ext_long_q <= 1'b1;
						phase_q    <= EXT;
					end else begin
						decl_q  <= LEN_WIDTH'(code);
						phase_q <= KEY;
					end
				end
				EXT: begin
					// big-endian shift in, saturating once the top byte is in use
					if (!too_long_q) begin
						if (|decl_q[LEN_WIDTH-1:LEN_WIDTH-8]) begin
							too_long_q <= 1'b1;
							decl_q     <= '1;
						end else begin
							decl_q <= {decl_q[LEN_WIDTH-9:0], stream.in_byte};
						end
					end
					hcount_q <= hcount_next;
					if (ext_done) begin
						hcount_q <= '0;
						phase_q  <= KEY;
					end
				end
				KEY: begin
					key_q[8*hcount_q[1:0] +: 8] <= stream.in_byte;
					hcount_q <= hcount_next;
					if (hcount_next == KEY_BYTES) begin
						hcount_q <= '0;
						done_q   <= '0;
						phase_q  <= (decl_q == '0) ? HDR0 : DATA;
					end
				end
				DATA: begin
					done_q <= done_next;
					if (last) begin
						phase_q  <= HDR0;
						hcount_q <= '0;
					end
				end
				default: begin
					hcount_q <= '0;
					phase_q  <= HDR1;
				end
			endcase
		end
	end

endmodule

@@ rtl/wfu_queue.sv @@
module wfu_queue #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != FULL_CNT;
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/wfu_output.sv @@
module wfu_output #(
	parameter int LEN_WIDTH = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  logic [LEN_WIDTH+17:0] q_data,
	wfu_frame_if.source           frames
);
	logic                 out_valid_q;
	logic [7:0]           payload_q;
	logic                 last_q;
	logic [LEN_WIDTH-1:0] length_q;
	logic                 error_q;
	logic                 load;

	assign q_ready = !out_valid_q || frames.ready;
	assign load    = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_ready) begin
			out_valid_q <= q_valid;
		end
	end

	// unmask: raw byte xor selected key byte
	always_ff @(posedge clk) begin
		if (load) begin
			payload_q <= q_data[7:0] ^ q_data[15:8];
			last_q    <= q_data[16];
			length_q  <= q_data[LEN_WIDTH+16:17];
			error_q   <= q_data[LEN_WIDTH+17];
		end
	end

	assign frames.valid        = out_valid_q;
	assign frames.payload_byte = payload_q;
	assign frames.last_byte    = last_q;
	assign frames.frame_length = length_q;
	assign frames.length_error = error_q;

endmodule

@@ rtl/websocket_frame_unmasker.sv @@
// WebSocket frame unmasker. Takes the framed byte stream on stream and returns
// each payload byte xored with its mask key byte on frames, marking the last
// byte of each frame and carrying the frame length (big-endian extended
// lengths, saturated at 2^LEN_WIDTH-1 with length_error set). Header and key
// bytes give no output; zero-length frames give none at all. The block takes
// one byte per cycle: header bytes are always taken, payload bytes are taken
// while the four-entry queue ahead of the output register has room, so a
// stalled output only holds the input back once that queue has filled.
// An accepted payload byte passes through the queue and the output register.
module websocket_frame_unmasker #(
	parameter int LEN_WIDTH = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	wfu_byte_if.sink    stream,
	wfu_frame_if.source frames
);
	import wfu_pkg::*;

	localparam int ITEM_W = LEN_WIDTH + 18;

	logic              push_valid;
	logic              push_ready;
	logic [ITEM_W-1:0] push_data;
	logic              pop_valid;
	logic              pop_ready;
	logic [ITEM_W-1:0] pop_data;

	wfu_parser #(.LEN_WIDTH(LEN_WIDTH)) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream),
		.q_valid (push_valid),
		.q_ready (push_ready),
		.q_data  (push_data)
	);

	wfu_queue #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	wfu_output #(.LEN_WIDTH(LEN_WIDTH)) u_output (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.q_data  (pop_data),
		.frames  (frames)
	);

endmodule

@@ tb/wfu_demask_checker.sv @@
`timescale 1ns / 100ps

module wfu_demask_checker #(
	parameter int LEN_WIDTH = 31
) (
	input  logic clk,
	input  logic arst_n,
	wfu_byte_if  stream,
	wfu_frame_if frames,
	output int   mismatches,
	output int   unmasked_left,
	output int   results_seen,
	output int   frames_seen
);
	import wfu_pkg::*;

	localparam logic [63:0] LEN_MAX = (64'd1 << LEN_WIDTH) - 64'd1;

	typedef enum logic [2:0] {
		SEEK_HDR0,
		SEEK_HDR1,
		TAKE_EXT,
		TAKE_KEY,
		TAKE_DATA
	} parse_phase_t;

	typedef struct packed {
		logic [7:0]           payload_byte;
		logic                 last_byte;
		logic [LEN_WIDTH-1:0] frame_length;
		logic                 length_error;
	} unmasked_t;

	parse_phase_t         phase;
	logic [3:0]           hdr_cnt;
	logic [3:0]           ext_need;
	logic [LEN_WIDTH-1:0] decl_len;
	logic [31:0]          xor_word;
	logic [LEN_WIDTH-1:0] done_cnt;
	logic                 saturated;

	unmasked_t unmasked_due[$];

	// advance the parser by one byte; returns 1 when a payload byte comes out
	function automatic bit demask_step(input logic [7:0] b, output unmasked_t res);
		logic [63:0] grown;
		logic [6:0]  code;
		logic [7:0]  kb;
		res = '0;
		case (phase)
			SEEK_HDR1: begin
				code = b[6:0] & LEN_CODE_MASK;
				decl_len = '0;
				saturated = 1'b0;
				xor_word = '0;
				done_cnt = '0;
				hdr_cnt = '0;
				if (code == LEN_CODE_EXT16) begin
					ext_need = EXT16_BYTES;
					phase = TAKE_EXT;
				end else if (code == LEN_CODE_EXT64) begin
					ext_need = EXT64_BYTES;
					phase = TAKE_EXT;
				end else begin
					decl_len = LEN_WIDTH'(code);
					phase = TAKE_KEY;
				end
				return 1'b0;
			end
			TAKE_EXT: begin
				// big-endian length, sticks at the maximum once it overflows
				if (!saturated) begin
					if (64'(decl_len) > (LEN_MAX >> 8)) begin
						saturated = 1'b1;
						decl_len = LEN_MAX[LEN_WIDTH-1:0];
					end else begin
						grown = (64'(decl_len) << 8) | 64'(b);
						if (grown > LEN_MAX) begin
							saturated = 1'b1;
							decl_len = LEN_MAX[LEN_WIDTH-1:0];
						end else begin
							decl_len = grown[LEN_WIDTH-1:0];
						end
					end
				end
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt >= ext_need) begin
					hdr_cnt = '0;
					phase = TAKE_KEY;
				end
				return 1'b0;
			end
			TAKE_KEY: begin
				xor_word = xor_word | ({24'b0, b} << (8 * hdr_cnt[1:0]));
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt >= KEY_BYTES) begin
					hdr_cnt = '0;
					done_cnt = '0;
					phase = (decl_len == '0) ? SEEK_HDR0 : TAKE_DATA;
				end
				return 1'b0;
			end
			TAKE_DATA: begin
				kb = xor_word[8 * done_cnt[1:0] +: 8];
				done_cnt = done_cnt + 1'b1;
				res.payload_byte = b ^ kb;
				res.last_byte = (done_cnt >= decl_len);
				res.frame_length = decl_len;
				res.length_error = saturated;
				if (done_cnt >= decl_len) begin
					phase = SEEK_HDR0;
					hdr_cnt = '0;
				end
				return 1'b1;
			end
			default: begin
				hdr_cnt = '0;
				phase = SEEK_HDR1;
				return 1'b0;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		unmasked_t want;
		unmasked_t got;
		if (!arst_n) begin
			phase = SEEK_HDR0;
			hdr_cnt = '0;
			ext_need = '0;
			decl_len = '0;
			xor_word = '0;
			done_cnt = '0;
			saturated = 1'b0;
			unmasked_due.delete();
			mismatches = 0;
			unmasked_left = 0;
			results_seen = 0;
			frames_seen = 0;
		end else begin
			if (stream.valid && stream.ready) begin
				if (demask_step(stream.in_byte, want))
					unmasked_due.push_back(want);
			end
			if (frames.valid && frames.ready) begin
				got.payload_byte = frames.payload_byte;
				got.last_byte = frames.last_byte;
				got.frame_length = frames.frame_length;
				got.length_error = frames.length_error;
				results_seen++;
				if (got.last_byte)
					frames_seen++;
				if (unmasked_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: byte %02h last %0d len %0d err %0d",
							got.payload_byte, got.last_byte, got.frame_length,
							got.length_error);
					mismatches++;
				end else begin
					want = unmasked_due.pop_front();
					if (got.payload_byte !== want.payload_byte
						|| got.last_byte !== want.last_byte
						|| got.frame_length !== want.frame_length
						|| got.length_error !== want.length_error) begin
						if (mismatches < 10) begin
							$display("mismatch at result %0d: want byte %02h last %0d len %0d err %0d",
								results_seen, want.payload_byte, want.last_byte,
								want.frame_length, want.length_error);
							$display("  got byte %02h last %0d len %0d err %0d",
								got.payload_byte, got.last_byte, got.frame_length,
								got.length_error);
						end
						mismatches++;
					end
				end
			end
			unmasked_left = unmasked_due.size();
		end
	end

endmodule

@@ tb/websocket_frame_unmasker_test.sv @@
`timescale 1ns / 100ps

module websocket_frame_unmasker_test;
	import wfu_pkg::*;

	localparam int LEN_WIDTH = 31;
	localparam int LIMIT = 1_500_000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_BYTES = 400;

	typedef enum int {
		LEN_SHORT,
		LEN_EXT16,
		LEN_EXT64
	} len_form_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int holds_asked = 0;
	int holds_started = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int cycles = 0;

	int mismatches;
	int unmasked_left;
	int results_seen;
	int frames_seen;

	wfu_byte_if stream_bus ();
	wfu_frame_if #(.LEN_WIDTH(LEN_WIDTH)) frame_bus ();

	websocket_frame_unmasker #(.LEN_WIDTH(LEN_WIDTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_bus),
		.frames (frame_bus)
	);

	wfu_demask_checker #(.LEN_WIDTH(LEN_WIDTH)) demask_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.stream        (stream_bus),
		.frames        (frame_bus),
		.mismatches    (mismatches),
		.unmasked_left (unmasked_left),
		.results_seen  (results_seen),
		.frames_seen   (frames_seen)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left != 0) begin
			frame_bus.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_started != holds_asked) begin
			holds_started <= holds_started + 1;
			hold_left <= HOLD_CYCLES;
			frame_bus.ready <= 1'b0;
		end else begin
			frame_bus.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			stream_bus.valid <= 1'b0;
			@(posedge clk);
		end
		stream_bus.valid <= 1'b1;
		stream_bus.in_byte <= b;
		@(posedge clk);
		while (!stream_bus.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// body is the number of payload bytes actually sent
	task automatic send_frame(input len_form_t form, input logic [63:0] len,
		input int body, input logic [31:0] key);
		logic mask_bit;
		mask_bit = 1'($urandom_range(1));
		send_byte(8'($urandom_range(255)));
		case (form)
			LEN_SHORT: begin
				send_byte({mask_bit, len[6:0]});
			end
			LEN_EXT16: begin
				send_byte({mask_bit, LEN_CODE_EXT16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			default: begin
				send_byte({mask_bit, LEN_CODE_EXT64});
				for (int i = 7; i >= 0; i--)
					send_byte(len[8 * i +: 8]);
			end
		endcase
		for (int k = 0; k < 4; k++)
			send_byte(key[8 * k +: 8]);
		repeat (body)
			send_byte(8'($urandom_range(255)));
		frames_sent++;
	endtask

	initial begin
		int target;
		int pick;
		int len;
		stream_bus.valid = 1'b0;
		stream_bus.in_byte = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty frame, one-byte frame, short extended length
		send_frame(LEN_SHORT, 64'd0, 0, 32'hFFFF_FFFF);
		send_frame(LEN_SHORT, 64'd1, 1, 32'h0000_0000);
		send_frame(LEN_EXT16, 64'd3, 3, 32'h00FF_5AA5);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 80; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 80; end
				default: begin idle_pct = 6; stall_pct = 6; end
			endcase
			if (p == 0) begin
				// long 16-bit length frame while the output is held off
				holds_asked++;
				send_frame(LEN_EXT16, 64'd300, 300, $urandom);
			end
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					send_frame(len_form_t'($urandom_range(2)), 64'd0, 0, $urandom);
				end else if (pick < 55) begin
					len = $urandom_range(1, 12);
					send_frame(LEN_SHORT, 64'(len), len, $urandom);
				end else if (pick < 62) begin
					len = $urandom_range(100, 125);
					send_frame(LEN_SHORT, 64'(len), len, $urandom);
				end else if (pick < 82) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(256, 400)
						: $urandom_range(0, 40);
					send_frame(LEN_EXT16, 64'(len), len, $urandom);
				end else begin
					len = $urandom_range(0, 40);
					send_frame(LEN_EXT64, 64'(len), len, $urandom);
				end
			end
		end

		// oversized length saturates; the frame never ends, so it goes last
		idle_pct = 0;
		stall_pct = 0;
		send_frame(LEN_EXT64, 64'h8000_0000_0000_0001, 150, $urandom);
		stream_bus.valid <= 1'b0;

		while (unmasked_left != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("summary: %0d bytes in %0d frames sent, %0d payload bytes checked, %0d frames ended",
			bytes_sent, frames_sent, results_seen, frames_seen);
		$display("summary: covered empty, 7/16/64-bit length and saturated frames under stalls");
		if (mismatches == 0 && unmasked_left == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ websocket_frame_unmasker.f @@
rtl/wfu_pkg.sv
rtl/wfu_stream_if.sv
rtl/wfu_parser.sv
rtl/wfu_queue.sv
rtl/wfu_output.sv
rtl/websocket_frame_unmasker.sv
tb/wfu_demask_checker.sv
tb/websocket_frame_unmasker_test.sv
